// ===== rtl/rcpc_pkg.sv =====
package rcpc_pkg;

  localparam int COORD_W    = 24;
  localparam int NORM_W     = 16;
  localparam int TIME_W     = 30;
  localparam int HIT_EDGE_W = 8;
  localparam int MAX_EDGES  = 256;
  localparam int EDGE_W     = $clog2(MAX_EDGES);

  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = NORM_W + DIFF_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = PROD_W;
  localparam int T_W        = 32;
  localparam int FRAC_SHIFT = 16;
  localparam int DIVD_W     = NUM_W + FRAC_SHIFT;
  localparam int DIVS_W     = DEN_W + TIME_W;
  localparam int DCNT_W     = $clog2(TIME_W + 1);

  localparam int MSTEP_W    = 3;
  localparam logic [MSTEP_W-1:0] MAC_LAST = 3'd4;

  localparam logic [TIME_W-1:0] TIME_LIMIT = TIME_W'(10000 * 65536);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd3;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [DIFF_W-1:0] dpx;
    logic signed [DIFF_W-1:0] dpy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } mac_ops_t;

endpackage

// ===== rtl/rcpc_edge_if.sv =====
interface rcpc_edge_if import rcpc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] edge_point_x;
  logic signed [COORD_W-1:0] edge_point_y;
  logic signed [NORM_W-1:0]  edge_normal_x;
  logic signed [NORM_W-1:0]  edge_normal_y;
  logic                      outer_polygon;
  logic                      last_edge;

  modport source (
    output valid, edge_point_x, edge_point_y, edge_normal_x, edge_normal_y,
           outer_polygon, last_edge,
    input  ready
  );

  modport sink (
    input  valid, edge_point_x, edge_point_y, edge_normal_x, edge_normal_y,
           outer_polygon, last_edge,
    output ready
  );
endinterface

// ===== rtl/rcpc_res_if.sv =====
interface rcpc_res_if import rcpc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [TIME_W-1:0]     hit_time;
  logic [HIT_EDGE_W-1:0] hit_edge;

  modport source (
    output valid, hit, hit_time, hit_edge,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_time, hit_edge,
    output ready
  );
endinterface

// ===== rtl/rcpc_mac.sv =====
module rcpc_mac import rcpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  mac_ops_t                ops,
  output logic                    done,
  output logic signed [NUM_W-1:0] num,
  output logic signed [DEN_W-1:0] den
);

  logic                     busy_r;
  logic [MSTEP_W-1:0]       step_r;
  logic                     done_r;
  logic signed [NORM_W-1:0] op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [DEN_W-1:0]  den_r;

  // step 0,1: num terms; step 2,3: den terms
  always_comb begin
    case (step_r)
      3'd0: begin
        op_a = ops.nx;
        op_b = ops.dpx;
      end
      3'd1: begin
        op_a = ops.ny;
        op_b = ops.dpy;
      end
      3'd2: begin
        op_a = ops.nx;
        op_b = ops.dx;
      end
      default: begin
        op_a = ops.ny;
        op_b = ops.dy;
      end
    endcase
  end

  assign prod_c = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == MAC_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prod_r <= prod_c;
      case (step_r)
        3'd1: acc_r <= prod_r;
        3'd2: num_r <= NUM_W'(acc_r) + NUM_W'(prod_r);
        3'd3: acc_r <= prod_r;
        3'd4: den_r <= acc_r + prod_r;
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign num  = num_r;
  assign den  = den_r;

endmodule

// ===== rtl/rcpc_div.sv =====
module rcpc_div import rcpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [T_W-1:0]   t
);

  logic                busy_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic                done_r;
  logic                neg_r;
  logic                sat_r;
  logic [DIVD_W-1:0]   rem_r;
  logic [DIVS_W-1:0]   dvs_r;
  logic [TIME_W-1:0]   quo_r;
  logic [NUM_W-1:0]    num_mag;
  logic [DEN_W-1:0]    den_mag;
  logic                ge;
  logic [TIME_W-1:0]   mag;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign ge      = DIVS_W'(rem_r) >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(TIME_W);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // first step only detects a quotient beyond the time range
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {num_mag, {FRAC_SHIFT{1'b0}}};
      dvs_r <= {den_mag, {TIME_W{1'b0}}};
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
      sat_r <= 1'b0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dvs_r[DIVD_W-1:0];
      if (cnt_r == DCNT_W'(TIME_W)) sat_r <= ge;
      else quo_r <= {quo_r[TIME_W-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
  end

  assign mag  = sat_r ? '1 : quo_r;
  assign t    = neg_r ? -$signed(T_W'(mag)) : $signed(T_W'(mag));
  assign done = done_r;

endmodule

// ===== rtl/ray_convex_polygon_clip.sv =====
// Clips a 2D ray against convex polygons streamed one edge per transfer. Each
// edge narrows an entry/exit interval starting at [0, 10000]; the last edge of
// a polygon returns one result (exit for the outer polygon, entry otherwise)
// and clears the per-polygon state. The radix-2 divider works in 31
// compare-subtract steps; an edge with den = 0 skips the divider. A last edge
// also waits in its update cycle while the previous result is unaccepted.
// Four serial multiplies on one 16x25 multiplier form num and den. in ready
// is low while an edge is in work. The user must write the ray registers only
// when idle; the block itself does not enforce this.
module ray_convex_polygon_clip import rcpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rcpc_edge_if.sink             in_edge,
  rcpc_res_if.source            out_result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] origin_x_r, origin_y_r, dir_x_r, dir_y_r;

  logic signed [NORM_W-1:0] nx_r, ny_r;
  logic signed [DIFF_W-1:0] dpx_r, dpy_r;
  logic                     outer_r, last_r;

  logic [TIME_W-1:0] entry_time_r, exit_time_r, entry_time_nxt, exit_time_nxt;
  logic [EDGE_W-1:0] entry_edge_r, exit_edge_r, entry_edge_nxt, exit_edge_nxt;
  logic [EDGE_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic              missed_r, missed_nxt, ahead_r, ahead_nxt;

  logic                  out_valid_r, out_hit_r;
  logic [TIME_W-1:0]     out_time_r;
  logic [HIT_EDGE_W-1:0] out_edge_r;
  logic                  hit_c;
  logic [TIME_W-1:0]     time_c;
  logic [EDGE_W-1:0]     edge_c;

  mac_ops_t                ops;
  logic                    accept, mac_done, div_start, div_done, upd_go;
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  logic signed [T_W-1:0]   t, entry_s, exit_s;
  logic                    den_nz, den_neg, behind;

  assign in_edge.ready = (state_r == ST_IDLE);
  assign accept        = in_edge.valid && in_edge.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= 24'sd38400;
      origin_y_r <= 24'sd76800;
      dir_x_r    <= 24'sd2560;
      dir_y_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        REG_DIR_X:    dir_x_r    <= cfg_data;
        REG_DIR_Y:    dir_y_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nx_r    <= in_edge.edge_normal_x;
      ny_r    <= in_edge.edge_normal_y;
      dpx_r   <= DIFF_W'(in_edge.edge_point_x) - DIFF_W'(origin_x_r);
      dpy_r   <= DIFF_W'(in_edge.edge_point_y) - DIFF_W'(origin_y_r);
      outer_r <= in_edge.outer_polygon;
      last_r  <= in_edge.last_edge;
    end
  end

  assign ops.nx  = nx_r;
  assign ops.ny  = ny_r;
  assign ops.dpx = dpx_r;
  assign ops.dpy = dpy_r;
  assign ops.dx  = DIFF_W'(dir_x_r);
  assign ops.dy  = DIFF_W'(dir_y_r);

  rcpc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .ops   (ops),
    .done  (mac_done),
    .num   (num),
    .den   (den)
  );

  assign den_nz    = (den != '0);
  assign den_neg   = den[DEN_W-1];
  assign div_start = (state_r == ST_MUL) && mac_done && den_nz;

  rcpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .t     (t)
  );

  assign upd_go = !last_r || !out_valid_r || out_result.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL: begin
        if (mac_done) state_nxt = den_nz ? ST_DIV : ST_UPD;
      end
      ST_DIV: if (div_done) state_nxt = ST_UPD;
      ST_UPD: if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign entry_s = $signed(T_W'(entry_time_r));
  assign exit_s  = $signed(T_W'(exit_time_r));
  assign behind  = (num != '0) && (num[NUM_W-1] != den_neg);

  always_comb begin
    entry_time_nxt = entry_time_r;
    exit_time_nxt  = exit_time_r;
    entry_edge_nxt = entry_edge_r;
    exit_edge_nxt  = exit_edge_r;
    missed_nxt     = missed_r;
    ahead_nxt      = ahead_r;
    if (!missed_r) begin
      if (den_nz) begin
        if (den_neg) begin
          if (t > exit_s) begin
            missed_nxt = 1'b1;
          end else if (t > entry_s) begin
            entry_time_nxt = t[TIME_W-1:0];
            entry_edge_nxt = edge_cnt_r;
          end
        end else begin
          if (t < entry_s) begin
            missed_nxt = 1'b1;
          end else if (t < exit_s) begin
            exit_time_nxt = t[TIME_W-1:0];
            exit_edge_nxt = edge_cnt_r;
          end
        end
      end
      if (!missed_nxt && !behind) ahead_nxt = 1'b1;
    end
    edge_cnt_nxt = (edge_cnt_r == EDGE_W'(MAX_EDGES - 1)) ? '0 : edge_cnt_r + 1'b1;

    hit_c  = 1'b0;
    time_c = '0;
    edge_c = '0;
    if (!missed_nxt && ahead_nxt) begin
      if (outer_r) begin
        if (exit_time_nxt < TIME_LIMIT) begin
          hit_c  = 1'b1;
          time_c = exit_time_nxt;
          edge_c = exit_edge_nxt;
        end
      end else if (entry_time_nxt != '0) begin
        hit_c  = 1'b1;
        time_c = entry_time_nxt;
        edge_c = entry_edge_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      entry_time_r <= '0;
      exit_time_r  <= TIME_LIMIT;
      entry_edge_r <= '0;
      exit_edge_r  <= '0;
      edge_cnt_r   <= '0;
      missed_r     <= 1'b0;
      ahead_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD && upd_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_UPD && upd_go) begin
        if (last_r) begin
          entry_time_r <= '0;
          exit_time_r  <= TIME_LIMIT;
          entry_edge_r <= '0;
          exit_edge_r  <= '0;
          edge_cnt_r   <= '0;
          missed_r     <= 1'b0;
          ahead_r      <= 1'b0;
        end else begin
          entry_time_r <= entry_time_nxt;
          exit_time_r  <= exit_time_nxt;
          entry_edge_r <= entry_edge_nxt;
          exit_edge_r  <= exit_edge_nxt;
          edge_cnt_r   <= edge_cnt_nxt;
          missed_r     <= missed_nxt;
          ahead_r      <= ahead_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && upd_go && last_r) begin
      out_hit_r  <= hit_c;
      out_time_r <= time_c;
      out_edge_r <= HIT_EDGE_W'(edge_c);
    end
  end

  assign out_result.valid    = out_valid_r;
  assign out_result.hit      = out_hit_r;
  assign out_result.hit_time = out_time_r;
  assign out_result.hit_edge = out_edge_r;

`ifndef SYNTH
  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    !missed_r |-> entry_time_r <= exit_time_r)
    else $error("entry bound above exit bound");

  a_exit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    exit_time_r <= TIME_LIMIT)
    else $error("exit bound beyond time limit");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_time_r == '0 && out_edge_r == '0)
    else $error("miss result carries nonzero fields");

  a_mac_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MUL)
    else $error("dot product finished outside multiply phase");
`endif

endmodule
